### hw/rtl/lcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and helpers of the lasso coordinate-step pipeline.
// ----------------------------------------------------------------------------
package lcs_pkg;

  // Fixed-point format and signed 32-bit limits
  localparam int unsigned QF = 16;
  localparam logic [16:0] Q_ONE = 17'h10000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Configuration register indexes
  localparam logic [1:0] CFG_LAMBDA = 2'd0;
  localparam logic [1:0] CFG_SHARE  = 2'd1;
  localparam logic [1:0] CFG_BAND   = 2'd2;

  // Configuration reset values
  localparam logic [30:0] LAMBDA_RST = 31'd65536;
  localparam logic [16:0] SHARE_RST  = 17'd65536;
  localparam logic [16:0] BAND_RST   = 17'd1;

  // Side data that rides along the root and first divide
  typedef struct packed {
    logic signed [31:0] g;
    logic signed [31:0] h;
    logic signed [31:0] c;
    logic               grp;
    logic               pen;
    logic               nsmall;
    logic [30:0]        l1;
  } lcs_side_t;

  // Payload of the root stage
  typedef struct packed {
    lcs_side_t   side;
    logic [62:0] cc;
    logic [30:0] l2p;
    logic [30:0] norm;
    logic        cpos;
    logic        cneg;
  } lcs_sq_t;

  // Payload of the final divide
  typedef struct packed {
    logic signed [31:0] c;
    logic               cpos;
    logic               cneg;
    logic               use_div;
    logic               fpre;
  } lcs_fin_t;

  // Clamp a 50-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = S32_MAX;
    end else if (v < -50'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lasso_coordinate_step.sv
`default_nettype none
// Throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and out_ready_i is low.
// The depth is set by the root and two dividers in series.
// Reset: rst_ni clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// lasso_coordinate_step
// Coordinate-descent step with L1 soft threshold or mixed group penalty,
// signed Q16.16, pipelined over root, divide, multiply and divide stages.
// ----------------------------------------------------------------------------
module lasso_coordinate_step
  import lcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] grad_sum_i,
  input  logic signed [31:0] hess_sum_i,
  input  logic signed [31:0] coef_now_i,
  input  logic               in_group_i,
  input  logic [30:0]        group_norm_sq_i,
  input  logic               penalized_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] step_o,
  output logic               overflow_o
);

  localparam int unsigned SQW = $bits(lcs_sq_t);
  localparam int unsigned SDW = $bits(lcs_side_t);
  localparam int unsigned FNW = $bits(lcs_fin_t);

  logic en;

  // Configuration registers
  logic [30:0] lambda_q;
  logic [16:0] share_q;
  logic [16:0] band_q;

  // Stage valid bits
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, out_v_q;

  // Stage 0: input capture
  logic signed [31:0] g0_q, h0_q, c0_q;
  logic               grp0_q, pen0_q;
  logic [30:0]        norm0_q;

  // Stage 1: products and compares
  logic [16:0]        share_c;
  logic [47:0]        pl1_d, pl1_q;
  logic signed [63:0] pcc_d, pcc_q;
  logic               cpos_d, cneg_d, nsm_d;
  logic               cpos1_q, cneg1_q, nsm1_q;
  logic signed [31:0] g1_q, h1_q, c1_q;
  logic               grp1_q, pen1_q;
  logic [30:0]        norm1_q;

  logic [30:0] l1_w, l2p_w;
  lcs_side_t   side1;
  lcs_sq_t     sq_in, sq_out;
  logic [SQW-1:0] sq_pay;
  logic        sq_v;
  logic [23:0] root_w;

  // Dividers after the root
  logic               dv_l2, dv_rat, fl2_w, frat_w;
  logic signed [31:0] l2_w, rat_w;
  logic [SDW-1:0]     side_pay;
  logic [1:0]         rat_pay;
  lcs_side_t          side2;

  // Stage 2: Hessian and penalty products
  logic signed [32:0] om_d;
  logic signed [64:0] m1_d, m1_q;
  logic signed [63:0] m2_d, m2_q;
  lcs_side_t          side2_q;
  logic               cpos2_q, cneg2_q, fl2_q, frat_q;
  logic signed [31:0] l2_q;

  // Stage 3: case selection
  logic signed [49:0] hsum, fsum, hzsum;
  logic signed [31:0] t_d, hh_d, t3_q, hh3_q;
  logic               fpre_d, dz_d;
  logic signed [31:0] g3_q, c3_q;
  logic               fpre3_q, dz3_q, cpos3_q, cneg3_q;

  // Stage 4: numerator and divisor magnitude
  logic signed [32:0] g33, t33, x_d, x4_q;
  logic               sub_d, add_d;
  logic [31:0]        hmag_d, hmag4_q;
  logic               hneg4_q, use4_q, fpre4_q, cpos4_q, cneg4_q;
  logic signed [31:0] c4_q;

  // Stage 5: unsigned divide operands
  logic [32:0]        xmag_d;
  logic [48:0]        num5_q;
  logic [31:0]        hmag5_q;
  logic               neg5_q;
  lcs_fin_t           fin5_q;

  // Final divide and output
  logic               fv, fovf;
  logic signed [31:0] fq;
  logic [FNW-1:0]     fin_pay;
  lcs_fin_t           fp;
  logic signed [31:0] step_d, s0;
  logic signed [32:0] csum;
  logic               flag_d;
  logic signed [31:0] step_q;
  logic               ovf_q;

  // Hold every stage while the output beat waits
  assign en          = !out_v_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= LAMBDA_RST;
      share_q  <= SHARE_RST;
      band_q   <= BAND_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CFG_LAMBDA: lambda_q <= cfg_data_i[30:0];
        CFG_SHARE:  share_q  <= cfg_data_i[16:0];
        CFG_BAND:   band_q   <= cfg_data_i[16:0];
        default: begin
        end
      endcase
    end
  end

  // Stage 1 logic
  assign share_c = (share_q > Q_ONE) ? Q_ONE : share_q;
  assign pl1_d   = 48'(share_c) * 48'(lambda_q);
  assign pcc_d   = c0_q * c0_q;
  assign cpos_d  = $signed({c0_q[31], c0_q}) > $signed({16'b0, band_q});
  assign cneg_d  = $signed({c0_q[31], c0_q}) < -$signed({16'b0, band_q});
  assign nsm_d   = norm0_q < 31'(band_q);

  // Split lambda and pack the root payload
  assign l1_w  = pl1_q[46:16];
  assign l2p_w = lambda_q - l1_w;
  always_comb begin
    side1.g      = g1_q;
    side1.h      = h1_q;
    side1.c      = c1_q;
    side1.grp    = grp1_q;
    side1.pen    = pen1_q;
    side1.nsmall = nsm1_q;
    side1.l1     = l1_w;
    sq_in.side   = side1;
    sq_in.cc     = pcc_q[62:0];
    sq_in.l2p    = l2p_w;
    sq_in.norm   = norm1_q;
    sq_in.cpos   = cpos1_q;
    sq_in.cneg   = cneg1_q;
  end

  lcs_sqrt #(
    .IW (47),
    .PW (SQW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .rad_i   ({norm1_q, 16'b0}),
    .pay_i   (sq_in),
    .valid_o (sq_v),
    .root_o  (root_w),
    .pay_o   (sq_pay)
  );

  assign sq_out = lcs_sq_t'(sq_pay);

  // Group L2 weight over the root of the norm
  lcs_div #(
    .NW (47),
    .DW (24),
    .PW (SDW)
  ) u_div_l2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .num_i   ({sq_out.l2p, 16'b0}),
    .den_i   (root_w),
    .neg_i   (1'b0),
    .pay_i   (sq_out.side),
    .valid_o (dv_l2),
    .quo_o   (l2_w),
    .ovf_o   (fl2_w),
    .pay_o   (side_pay)
  );

  // Squared coefficient over the group norm
  lcs_div #(
    .NW (63),
    .DW (31),
    .PW (2)
  ) u_div_rat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .num_i   (sq_out.cc),
    .den_i   (sq_out.norm),
    .neg_i   (1'b0),
    .pay_i   ({sq_out.cpos, sq_out.cneg}),
    .valid_o (dv_rat),
    .quo_o   (rat_w),
    .ovf_o   (frat_w),
    .pay_o   (rat_pay)
  );

  assign side2 = lcs_side_t'(side_pay);

  // Stage 2 logic
  assign om_d = $signed(33'd65536) - $signed({rat_w[31], rat_w});
  assign m1_d = l2_w * om_d;
  assign m2_d = l2_w * side2.c;

  // Stage 3 logic: pick threshold, Hessian and flag per case
  assign hsum  = $signed({{18{side2_q.h[31]}}, side2_q.h}) +
                 $signed({m1_q[64], m1_q[64:16]});
  assign fsum  = cpos2_q ?
                 ($signed({19'b0, side2_q.l1}) + $signed({{2{m2_q[63]}}, m2_q[63:16]})) :
                 ($signed({19'b0, side2_q.l1}) - $signed({{2{m2_q[63]}}, m2_q[63:16]}));
  assign hzsum = $signed({{18{side2_q.h[31]}}, side2_q.h}) +
                 $signed({{18{l2_q[31]}}, l2_q});

  always_comb begin
    if (!side2_q.grp) begin
      t_d    = side2_q.pen ? $signed({1'b0, lambda_q}) : 32'sd0;
      hh_d   = side2_q.h;
      fpre_d = 1'b0;
      dz_d   = !(cpos2_q || cneg2_q);
    end else if (cpos2_q || cneg2_q) begin
      t_d    = sat32(fsum);
      hh_d   = sat32(hsum);
      fpre_d = fl2_q || frat_q;
      dz_d   = 1'b0;
    end else if (side2_q.nsmall) begin
      t_d    = $signed({1'b0, lambda_q});
      hh_d   = side2_q.h;
      fpre_d = 1'b0;
      dz_d   = 1'b1;
    end else begin
      t_d    = $signed({1'b0, side2_q.l1});
      hh_d   = sat32(hzsum);
      fpre_d = fl2_q;
      dz_d   = 1'b1;
    end
  end

  // Stage 4 logic: soft threshold and divisor magnitude
  assign g33    = $signed({g3_q[31], g3_q});
  assign t33    = $signed({t3_q[31], t3_q});
  assign sub_d  = dz3_q ? (g33 > t33) : cpos3_q;
  assign add_d  = dz3_q ? (g33 < -t33) : cneg3_q;
  assign x_d    = sub_d ? (g33 - t33) : (g33 + t33);
  assign hmag_d = hh3_q[31] ? (32'd0 - hh3_q) : hh3_q;

  // Stage 5 logic
  assign xmag_d = x4_q[32] ? (33'd0 - x4_q) : x4_q;

  lcs_div #(
    .NW (49),
    .DW (32),
    .PW (FNW)
  ) u_div_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .num_i   (num5_q),
    .den_i   (hmag5_q),
    .neg_i   (neg5_q),
    .pay_i   (fin5_q),
    .valid_o (fv),
    .quo_o   (fq),
    .ovf_o   (fovf),
    .pay_o   (fin_pay)
  );

  assign fp = lcs_fin_t'(fin_pay);

  // Drop a step that carries the coefficient across zero
  assign s0   = fp.use_div ? fq : 32'sd0;
  assign csum = $signed({fp.c[31], fp.c}) + $signed({s0[31], s0});
  always_comb begin
    step_d = s0;
    if ((fp.cpos && csum < 0) || (fp.cneg && csum > 0)) begin
      step_d = 32'sd0;
    end
  end
  assign flag_d = fp.fpre || (fp.use_div && fovf);

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v0_q    <= in_valid_i;
      v1_q    <= v0_q;
      v2_q    <= dv_l2;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      out_v_q <= fv;
    end
  end

  // Advance data
  always_ff @(posedge clk_i) begin
    if (en) begin
      g0_q    <= grad_sum_i;
      h0_q    <= hess_sum_i;
      c0_q    <= coef_now_i;
      grp0_q  <= in_group_i;
      norm0_q <= group_norm_sq_i;
      pen0_q  <= penalized_i;

      pl1_q   <= pl1_d;
      pcc_q   <= pcc_d;
      cpos1_q <= cpos_d;
      cneg1_q <= cneg_d;
      nsm1_q  <= nsm_d;
      g1_q    <= g0_q;
      h1_q    <= h0_q;
      c1_q    <= c0_q;
      grp1_q  <= grp0_q;
      pen1_q  <= pen0_q;
      norm1_q <= norm0_q;

      m1_q    <= m1_d;
      m2_q    <= m2_d;
      side2_q <= side2;
      cpos2_q <= rat_pay[1];
      cneg2_q <= rat_pay[0];
      fl2_q   <= fl2_w;
      frat_q  <= frat_w;
      l2_q    <= l2_w;

      t3_q    <= t_d;
      hh3_q   <= hh_d;
      fpre3_q <= fpre_d;
      dz3_q   <= dz_d;
      g3_q    <= side2_q.g;
      c3_q    <= side2_q.c;
      cpos3_q <= cpos2_q;
      cneg3_q <= cneg2_q;

      x4_q    <= x_d;
      hmag4_q <= hmag_d;
      hneg4_q <= hh3_q[31];
      use4_q  <= sub_d || add_d;
      fpre4_q <= fpre3_q;
      c4_q    <= c3_q;
      cpos4_q <= cpos3_q;
      cneg4_q <= cneg3_q;

      num5_q         <= {xmag_d[31:0], 16'b0} | {xmag_d[32], 48'b0};
      hmag5_q        <= hmag4_q;
      neg5_q         <= (hmag4_q == 32'd0) ? x4_q[32] : (x4_q[32] ^ hneg4_q);
      fin5_q.c       <= c4_q;
      fin5_q.cpos    <= cpos4_q;
      fin5_q.cneg    <= cneg4_q;
      fin5_q.use_div <= use4_q;
      fin5_q.fpre    <= fpre4_q;

      step_q  <= step_d;
      ovf_q   <= flag_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign step_o      = step_q;
  assign overflow_o  = ovf_q;

`ifndef SYNTHESIS
  // Both dividers after the root run in lockstep
  a_div_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_l2 == dv_rat)
    else $error("group dividers out of step");

  // A kept step never carries a positive coefficient below zero
  a_clamp_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fv && fp.cpos) |-> ($signed({fp.c[31], fp.c}) + $signed({step_d[31], step_d}) >= 0))
    else $error("step crosses zero from above");

  // A kept step never carries a negative coefficient above zero
  a_clamp_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fv && fp.cneg) |-> ($signed({fp.c[31], fp.c}) + $signed({step_d[31], step_d}) <= 0))
    else $error("step crosses zero from below");
`endif

endmodule
`default_nettype wire

### hw/rtl/lcs_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_sqrt
// Pipelined integer square root, one root bit per stage, payload alongside.
// ----------------------------------------------------------------------------
module lcs_sqrt
  import lcs_pkg::*;
#(
  parameter int unsigned IW = 47,
  parameter int unsigned PW = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [IW-1:0]           rad_i,
  input  logic [PW-1:0]           pay_i,
  output logic                    valid_o,
  output logic [(IW+1)/2-1:0]     root_o,
  output logic [PW-1:0]           pay_o
);

  localparam int unsigned RB = (IW + 1) / 2;
  localparam int unsigned EW = 2 * RB;
  localparam int unsigned RW = RB + 2;

  logic [RB:0]   v_q;
  logic [EW-1:0] rad_q  [RB+1];
  logic [RW-1:0] rem_q  [RB+1];
  logic [RB-1:0] root_q [RB+1];
  logic [PW-1:0] pay_q  [RB+1];

  logic [RW-1:0] rem_nx  [RB];
  logic [RB-1:0] root_nx [RB];

  // One root digit per stage
  always_comb begin
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    for (int k = 0; k < RB; k++) begin
      cur   = {rem_q[k], rad_q[k][EW-1:EW-2]};
      trial = (RW+2)'({root_q[k], 2'b01});
      if (cur >= trial) begin
        rem_nx[k]  = RW'(cur - trial);
        root_nx[k] = {root_q[k][RB-2:0], 1'b1};
      end else begin
        rem_nx[k]  = cur[RW-1:0];
        root_nx[k] = {root_q[k][RB-2:0], 1'b0};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RB-1:0], valid_i};
    end
  end

  // Advance data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= EW'(rad_i);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      pay_q[0]  <= pay_i;
      for (int k = 0; k < RB; k++) begin
        rad_q[k+1]  <= {rad_q[k][EW-3:0], 2'b00};
        rem_q[k+1]  <= rem_nx[k];
        root_q[k+1] <= root_nx[k];
        pay_q[k+1]  <= pay_q[k];
      end
    end
  end

  assign valid_o = v_q[RB];
  assign root_o  = root_q[RB];
  assign pay_o   = pay_q[RB];

endmodule
`default_nettype wire

### hw/rtl/lcs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_div
// Pipelined saturating divide: 32 quotient bits, one per stage, with an
// up-front overflow test and a signed, clamped result.
// ----------------------------------------------------------------------------
module lcs_div
  import lcs_pkg::*;
#(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 32,
  parameter int unsigned PW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NW-1:0]      num_i,
  input  logic [DW-1:0]      den_i,
  input  logic               neg_i,
  input  logic [PW-1:0]      pay_i,
  output logic               valid_o,
  output logic signed [31:0] quo_o,
  output logic               ovf_o,
  output logic [PW-1:0]      pay_o
);

  localparam int unsigned QB = 32;
  localparam int unsigned HW = NW - QB;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  logic [QB+1:0] v_q;
  logic [DW-1:0] r_q   [QB+1];
  logic [QB-1:0] lo_q  [QB+1];
  logic [QB-1:0] qt_q  [QB+1];
  logic [DW-1:0] d_q   [QB+1];
  logic [PW-1:0] pay_q [QB+1];
  logic [QB:0]   ovf_q;
  logic [QB:0]   nz_q;
  logic [QB:0]   neg_q;

  logic [DW-1:0] r_nx [QB];
  logic [QB-1:0] bit_nx;

  logic signed [31:0] quo_d;
  logic               sat_d;
  logic [QB-1:0]      qm;

  logic signed [31:0] quo_q;
  logic               sat_q;
  logic [PW-1:0]      pout_q;

  // Quotient would need more than 32 bits when the high part reaches the divisor
  assign hi_ext  = CW'(num_i[NW-1:QB]);
  assign den_ext = CW'(den_i);

  // One restoring step per stage
  always_comb begin
    logic [DW:0] trial;
    for (int k = 0; k < QB; k++) begin
      trial = {r_q[k], lo_q[k][QB-1]};
      if (trial >= {1'b0, d_q[k]}) begin
        r_nx[k]   = DW'(trial - {1'b0, d_q[k]});
        bit_nx[k] = 1'b1;
      end else begin
        r_nx[k]   = trial[DW-1:0];
        bit_nx[k] = 1'b0;
      end
    end
  end

  // Apply sign and clamp
  assign qm = qt_q[QB];
  always_comb begin
    if (ovf_q[QB]) begin
      quo_d = nz_q[QB] ? (neg_q[QB] ? S32_MIN : S32_MAX) : 32'sd0;
      sat_d = 1'b1;
    end else if (!neg_q[QB]) begin
      if (qm[QB-1]) begin
        quo_d = S32_MAX;
        sat_d = 1'b1;
      end else begin
        quo_d = $signed(qm);
        sat_d = 1'b0;
      end
    end else if (qm > 32'h80000000) begin
      quo_d = S32_MIN;
      sat_d = 1'b1;
    end else begin
      quo_d = $signed(32'd0 - qm);
      sat_d = 1'b0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QB:0], valid_i};
    end
  end

  // Advance data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= hi_ext[DW-1:0];
      lo_q[0]  <= num_i[QB-1:0];
      qt_q[0]  <= '0;
      d_q[0]   <= den_i;
      ovf_q[0] <= (hi_ext >= den_ext);
      nz_q[0]  <= |num_i;
      neg_q[0] <= neg_i;
      pay_q[0] <= pay_i;
      for (int k = 0; k < QB; k++) begin
        r_q[k+1]   <= r_nx[k];
        lo_q[k+1]  <= {lo_q[k][QB-2:0], 1'b0};
        qt_q[k+1]  <= {qt_q[k][QB-2:0], bit_nx[k]};
        d_q[k+1]   <= d_q[k];
        ovf_q[k+1] <= ovf_q[k];
        nz_q[k+1]  <= nz_q[k];
        neg_q[k+1] <= neg_q[k];
        pay_q[k+1] <= pay_q[k];
      end
      quo_q  <= quo_d;
      sat_q  <= sat_d;
      pout_q <= pay_q[QB];
    end
  end

  assign valid_o = v_q[QB+1];
  assign quo_o   = quo_q;
  assign ovf_o   = sat_q;
  assign pay_o   = pout_q;

endmodule
`default_nettype wire
